// ===== hw/rtl/utf8d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf8d_pkg
// Shared types and constants for the streaming UTF-8 code point decoder.
// ============================================================================
package utf8d_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned LeftW = 2;

  // Result status codes
  localparam logic [1:0] ST_VALID      = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD   = 2'd1;
  localparam logic [1:0] ST_BEYOND_BMP = 2'd2;

  localparam logic [CpW-1:0] BMP_MAX = 21'h00FFFF;

  // Input request: one text byte with its end-of-string flag
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_req_t;

  // Result request: decoded code point and status
  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic [1:0]     status;
  } glyph_req_t;

  // Decoder state carried between bytes
  typedef struct packed {
    logic [LeftW-1:0] bytes_left;
    logic [CpW-1:0]   accumulator;
  } dec_state_t;

  // Outcome of one decode step
  typedef struct packed {
    logic       emit;
    glyph_req_t glyph;
  } step_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/utf8d_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf8d_step
// Combinational decode of one byte against the current decoder state.
// ============================================================================
module utf8d_step (
  input  utf8d_pkg::text_req_t  text,
  input  utf8d_pkg::dec_state_t state,
  output utf8d_pkg::dec_state_t state_next,
  output utf8d_pkg::step_res_t  res
);

  logic [7:0]                       b;
  logic                             last;
  logic [utf8d_pkg::CpW-1:0]        acc_m;
  logic [utf8d_pkg::LeftW-1:0]      left_m;
  logic                             flush;

  assign b    = text.text_byte;
  assign last = text.end_of_text;

  always_comb begin
    acc_m  = state.accumulator;
    left_m = state.bytes_left;
    flush  = 1'b0;
    res.emit  = 1'b0;
    res.glyph = '0;

    if (state.bytes_left != '0) begin
      // Continuation position: always consumed, merged only if 10xxxxxx
      if (b[7:6] == 2'b10) begin
        acc_m = {state.accumulator[utf8d_pkg::CpW-7:0], b[5:0]};
      end
      left_m = state.bytes_left - 2'd1;
      flush  = (left_m == '0) || last;
    end else begin
      unique case (b) inside
        8'b0???????: begin
          acc_m  = {13'd0, b};
          left_m = 2'd0;
          flush  = 1'b1;
        end
        8'b110?????: begin
          acc_m  = {16'd0, b[4:0]};
          left_m = 2'd1;
          flush  = last;
        end
        8'b1110????: begin
          acc_m  = {17'd0, b[3:0]};
          left_m = 2'd2;
          flush  = last;
        end
        8'b11110???: begin
          acc_m  = {18'd0, b[2:0]};
          left_m = 2'd3;
          flush  = last;
        end
        default: begin
          // Bad lead byte: report and stay idle
          acc_m  = '0;
          left_m = '0;
          res.emit  = 1'b1;
          res.glyph.code_point = '0;
          res.glyph.status     = utf8d_pkg::ST_BAD_LEAD;
        end
      endcase
    end

    if (flush) begin
      res.emit = 1'b1;
      res.glyph.code_point = acc_m;
      res.glyph.status = (acc_m > utf8d_pkg::BMP_MAX) ? utf8d_pkg::ST_BEYOND_BMP
                                                      : utf8d_pkg::ST_VALID;
      state_next = '0;
    end else begin
      state_next.bytes_left  = left_m;
      state_next.accumulator = acc_m;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_codepoint_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// utf8_codepoint_decoder
// Lenient streaming UTF-8 decoder: one byte in, zero or one code point out.
// ============================================================================
//
//  channel | handshake                | payload                    | per request
//  --------+--------------------------+----------------------------+-------------
//  text    | text_valid / text_stall  | text_byte, end_of_text     | one byte
//  glyph   | glyph_valid / glyph_stall| code_point, status         | 0 or 1 result
//
//  One byte per cycle sustained unless the result is stalled. A byte is held in
//  the input register, decoded by the step logic and, if it ends a character or
//  is a bad lead byte, loaded into the result register, which drives glyph_valid.
//  Synchronous active-high rst clears both valid flags and the decode state.
//  While the result register is stalled, the input register still takes one
//  more byte; further bytes are stalled until the result is taken.
//
module utf8_codepoint_decoder (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   text_valid,
  output logic                  text_stall,
  input  utf8d_pkg::text_req_t  text,
  output logic                  glyph_valid,
  input  wire                   glyph_stall,
  output utf8d_pkg::glyph_req_t glyph
);

  // Input register
  logic                  in_valid_q;
  utf8d_pkg::text_req_t  in_q;

  // Decode state
  utf8d_pkg::dec_state_t state;
  utf8d_pkg::dec_state_t state_next;
  utf8d_pkg::step_res_t  res;

  logic out_free;
  logic fire;
  logic take;

  // Result register can load when empty or being drained this cycle
  assign out_free   = !glyph_valid || !glyph_stall;
  // Decode the held byte only when its result (if any) has somewhere to go
  assign fire       = in_valid_q && out_free;
  // Hold the input register while its byte cannot advance
  assign text_stall = in_valid_q && !fire;
  assign take       = text_valid && !text_stall;

  utf8d_step u_step (
    .text       (in_q),
    .state      (state),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= text;
    end
  end

  // Advance the decode state once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Result register: load on emitting bytes, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= 1'b0;
    end else if (fire && res.emit) begin
      glyph_valid <= 1'b1;
    end else if (!glyph_stall) begin
      glyph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      glyph <= res.glyph;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_bad_lead_zero: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && (glyph.status == utf8d_pkg::ST_BAD_LEAD) |-> glyph.code_point == '0)
    else $error("bad lead result carries a non-zero code point");

  a_beyond_bmp: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && (glyph.status == utf8d_pkg::ST_BEYOND_BMP)
      |-> glyph.code_point > utf8d_pkg::BMP_MAX)
    else $error("beyond-BMP status on a BMP code point");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !in_valid_q |-> !text_stall)
    else $error("input stalled with empty input register");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && !glyph_stall && !(fire && res.emit) |=> !glyph_valid)
    else $error("taken result not dropped");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    glyph_valid && glyph_stall |=> glyph_valid && $stable(glyph))
    else $error("stalled result changed");

endmodule
`default_nettype wire
